@@ rtl/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tcrd_pkg.sv @@
package tcrd_pkg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] thread_id;
        logic        has_virtual_track;
        logic [31:0] virtual_track;
        logic [1:0]  record_kind;
        logic [63:0] frame;
        logic [63:0] begin_ticks;
        logic [63:0] end_ticks;
        logic [31:0] name_id;
        logic [1:0]  value_kind;
        logic [63:0] value_bits;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] code_scope_complete;
        logic [1:0] code_counter;
        logic [1:0] code_instant;
        logic [7:0] kind_unsigned_varint;
        logic [7:0] kind_signed_zigzag;
        logic [7:0] kind_raw_double;
    } t_cfg;

    localparam logic [1:0] ST_EVENT    = 2'd0;
    localparam logic [1:0] ST_EARLY    = 2'd1;
    localparam logic [1:0] ST_OVERLONG = 2'd2;

    localparam logic [1:0] VK_NONE = 2'd0;
    localparam logic [1:0] VK_UNS  = 2'd1;
    localparam logic [1:0] VK_SGN  = 2'd2;
    localparam logic [1:0] VK_RAW  = 2'd3;

    localparam logic [2:0] REG_CODE_SCOPE   = 3'd0;
    localparam logic [2:0] REG_CODE_COUNTER = 3'd1;
    localparam logic [2:0] REG_CODE_INSTANT = 3'd2;
    localparam logic [2:0] REG_KIND_UNS     = 3'd3;
    localparam logic [2:0] REG_KIND_ZZ      = 3'd4;
    localparam logic [2:0] REG_KIND_RAW     = 3'd5;

    function automatic logic [63:0] unzigzag(input logic [63:0] e);
        unzigzag = (e >> 1) ^ {64{e[0]}};
    endfunction

endpackage

@@ rtl/tcrd_front.sv @@
// Byte parser: header and record fields, produces zero, one or two results per byte
module tcrd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcrd_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  tcrd_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output tcrd_pkg::t_out_item o_res0,
    output tcrd_pkg::t_out_item o_res1,
    output logic               o_two
);
    typedef enum logic [3:0] {
        PH_THREAD, PH_SEQ, PH_TIME, PH_BFRAME, PH_COUNT, PH_TAG, PH_VTRACK,
        PH_FRAME, PH_BEGIN, PH_NAME, PH_DUR, PH_KIND, PH_VUNS, PH_VZZ,
        PH_VRAW, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_thread, n_thread;
    logic [63:0] r_tbase, n_tbase, r_fbase, n_fbase, r_left, n_left;
    logic [2:0]  r_tag, n_tag;
    logic [31:0] r_vtrack, n_vtrack, r_name, n_name;
    logic [63:0] r_frame, n_frame, r_begin, n_begin;
    logic        r_failed, n_failed;

    logic        r_valid, r_two;
    tcrd_pkg::t_out_item r_res0, r_res1;

    logic [7:0]  b;
    logic        fin;
    logic [63:0] acc_or, var_v, fix_v;
    logic [5:0]  sh;
    logic        vdone, vover, fdone;
    logic        ev, ovl, early;
    logic [63:0] ev_end, ev_vbits;
    logic [1:0]  ev_vk;
    logic        take;
    tcrd_pkg::t_out_item evr, st0, st1;

    assign b = i_item.payload_byte;
    assign fin = i_item.payload_end;
    assign o_ready = !r_valid || i_ready;
    assign take = i_valid && o_ready;

    always_comb begin
        sh = 6'((r_cnt * 7) & 63);
        var_v = r_acc | (64'(b[6:0]) << sh);
        fix_v = r_acc | (64'(b) << {r_cnt[2:0], 3'b000});
        vdone = !b[7];
        vover = b[7] && (r_cnt == 4'd9);
        fdone = (r_cnt[2:0] == 3'd7);
    end

    always_comb begin
        n_phase = r_phase; n_acc = r_acc; n_cnt = r_cnt; n_thread = r_thread;
        n_tbase = r_tbase; n_fbase = r_fbase; n_left = r_left; n_tag = r_tag;
        n_vtrack = r_vtrack; n_name = r_name; n_frame = r_frame;
        n_begin = r_begin; n_failed = r_failed;
        ev = 1'b0; ovl = 1'b0; ev_end = r_begin; ev_vk = tcrd_pkg::VK_NONE;
        ev_vbits = '0;
        if (!r_failed) begin
            unique case (r_phase)
                PH_THREAD, PH_SEQ, PH_BFRAME, PH_COUNT, PH_VTRACK, PH_FRAME,
                PH_BEGIN, PH_NAME, PH_DUR, PH_VUNS, PH_VZZ: begin
                    if (vdone) begin
                        n_acc = '0; n_cnt = '0;
                    end else begin
                        n_acc = var_v; n_cnt = r_cnt + 4'd1;
                        ovl = vover;
                    end
                end
                PH_TIME, PH_VRAW: begin
                    if (fdone) begin
                        n_acc = '0; n_cnt = '0;
                    end else begin
                        n_acc = fix_v; n_cnt = r_cnt + 4'd1;
                    end
                end
                default: ;
            endcase
            unique case (r_phase)
                PH_THREAD: if (vdone) begin
                    n_thread = var_v[31:0]; n_phase = PH_SEQ;
                end
                PH_SEQ: if (vdone) n_phase = PH_TIME;
                PH_TIME: if (fdone) begin
                    n_tbase = fix_v; n_phase = PH_BFRAME;
                end
                PH_BFRAME: if (vdone) begin
                    n_fbase = var_v; n_phase = PH_COUNT;
                end
                PH_COUNT: if (vdone) begin
                    n_left = var_v;
                    n_phase = (var_v != 0) ? PH_TAG : PH_DONE;
                end
                PH_TAG: begin
                    n_tag = b[2:0]; n_vtrack = '0;
                    n_phase = b[2] ? PH_VTRACK : PH_FRAME;
                end
                PH_VTRACK: if (vdone) begin
                    n_vtrack = var_v[31:0]; n_phase = PH_FRAME;
                end
                PH_FRAME: if (vdone) begin
                    n_frame = r_fbase + tcrd_pkg::unzigzag(var_v); n_phase = PH_BEGIN;
                end
                PH_BEGIN: if (vdone) begin
                    n_begin = r_tbase + var_v; n_phase = PH_NAME;
                end
                PH_NAME: if (vdone) begin
                    n_name = var_v[31:0];
                    if (r_tag[1:0] == i_cfg.code_scope_complete) n_phase = PH_DUR;
                    else if (r_tag[1:0] == i_cfg.code_counter) n_phase = PH_KIND;
                    else ev = 1'b1;
                end
                PH_DUR: if (vdone) begin
                    ev = 1'b1; ev_end = r_begin + var_v;
                end
                PH_KIND: begin
                    if (b == i_cfg.kind_unsigned_varint) n_phase = PH_VUNS;
                    else if (b == i_cfg.kind_signed_zigzag) n_phase = PH_VZZ;
                    else if (b == i_cfg.kind_raw_double) begin
                        n_phase = PH_VRAW; n_cnt = '0; n_acc = '0;
                    end else ev = 1'b1;
                end
                PH_VUNS: if (vdone) begin
                    ev = 1'b1; ev_vk = tcrd_pkg::VK_UNS; ev_vbits = var_v;
                end
                PH_VZZ: if (vdone) begin
                    ev = 1'b1; ev_vk = tcrd_pkg::VK_SGN;
                    ev_vbits = tcrd_pkg::unzigzag(var_v);
                end
                PH_VRAW: if (fdone) begin
                    ev = 1'b1; ev_vk = tcrd_pkg::VK_RAW; ev_vbits = fix_v;
                end
                PH_DONE: ;
                default: ;
            endcase
            if (ev) begin
                n_left = r_left - 64'd1;
                n_phase = (n_left != 0) ? PH_TAG : PH_DONE;
            end
            if (ovl) n_failed = 1'b1;
        end
        early = !r_failed && fin && !ovl && (n_phase != PH_DONE);
        if (fin) begin
            n_phase = PH_THREAD; n_acc = '0; n_cnt = '0; n_failed = 1'b0;
        end
    end

    always_comb begin
        evr = '0;
        evr.status = tcrd_pkg::ST_EVENT;
        evr.thread_id = r_thread;
        evr.has_virtual_track = r_tag[2];
        evr.virtual_track = r_vtrack;
        evr.record_kind = r_tag[1:0];
        evr.frame = r_frame;
        evr.begin_ticks = r_begin;
        evr.end_ticks = ev_end;
        evr.name_id = (r_phase == PH_NAME) ? var_v[31:0] : r_name;
        evr.value_kind = ev_vk;
        evr.value_bits = ev_vbits;
        st0 = '0;
        st0.status = ovl ? tcrd_pkg::ST_OVERLONG : tcrd_pkg::ST_EARLY;
        st0.last = 1'b1;
        st1 = st0;
        evr.last = !(ovl || early);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_THREAD; r_acc <= '0; r_cnt <= '0; r_thread <= '0;
            r_tbase <= '0; r_fbase <= '0; r_left <= '0; r_tag <= '0;
            r_vtrack <= '0; r_name <= '0; r_frame <= '0; r_begin <= '0;
            r_failed <= 1'b0; r_valid <= 1'b0; r_two <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_acc <= n_acc; r_cnt <= n_cnt;
                r_thread <= n_thread; r_tbase <= n_tbase; r_fbase <= n_fbase;
                r_left <= n_left; r_tag <= n_tag; r_vtrack <= n_vtrack;
                r_name <= n_name; r_frame <= n_frame; r_begin <= n_begin;
                r_failed <= n_failed;
                r_valid <= ev || ovl || early;
                r_two <= ev && (ovl || early);
                r_res0 <= ev ? evr : st0;
                r_res1 <= st1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_two = r_two;
    assign o_res0 = r_res0;
    assign o_res1 = r_res1;
endmodule

@@ rtl/tcrd_back.sv @@
// Result queue: takes one or two results at a time, hands them out one at a time
module tcrd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tcrd_pkg::t_out_item i_res0,
    input  tcrd_pkg::t_out_item i_res1,
    input  logic                i_two,
    output logic                o_valid,
    input  logic                i_ready,
    output tcrd_pkg::t_out_item o_item,
    output logic [2:0]          o_count
);
    tcrd_pkg::t_out_item r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt <= 3'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_res0;
            if (i_two) r_q[r_wp + 2'd1] <= i_res1;
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + (i_two ? 2'd2 : 2'd1);
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (push ? (i_two ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end
endmodule

@@ rtl/trace_chunk_record_decoder_core.sv @@
// A byte's results pass through the parser's output register, then the
// result queue. Throughput: one byte per cycle while the queue has room;
// a byte with two results is absorbed by the 4-entry result queue.
// Reset (synchronous, i_rst_n low): parse restarts at the header, config
// registers return to their defaults, queue empties.
`include "assert_macros.svh"
module trace_chunk_record_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tcrd_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output tcrd_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);
    tcrd_pkg::t_cfg      r_cfg;
    logic                f_valid, f_ready, f_two;
    tcrd_pkg::t_out_item f_res0, f_res1;
    logic [2:0]          q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{2'd0, 2'd1, 2'd2, 8'd0, 8'd1, 8'd2};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcrd_pkg::REG_CODE_SCOPE:   r_cfg.code_scope_complete <= i_cfg_data[1:0];
                tcrd_pkg::REG_CODE_COUNTER: r_cfg.code_counter <= i_cfg_data[1:0];
                tcrd_pkg::REG_CODE_INSTANT: r_cfg.code_instant <= i_cfg_data[1:0];
                tcrd_pkg::REG_KIND_UNS:     r_cfg.kind_unsigned_varint <= i_cfg_data;
                tcrd_pkg::REG_KIND_ZZ:      r_cfg.kind_signed_zigzag <= i_cfg_data;
                tcrd_pkg::REG_KIND_RAW:     r_cfg.kind_raw_double <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcrd_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid, .o_ready, .i_item,
        .o_valid(f_valid), .i_ready(f_ready),
        .o_res0(f_res0), .o_res1(f_res1), .o_two(f_two)
    );

    tcrd_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready),
        .i_res0(f_res0), .i_res1(f_res1), .i_two(f_two),
        .o_valid, .i_ready, .o_item, .o_count(q_count)
    );

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, q_count <= 3'd4, "queue overflow")
    `ASSERT_IMPL(a_status_zero, i_clk, i_rst_n, o_valid && o_item.status != tcrd_pkg::ST_EVENT,
        o_item.frame == 64'd0 && o_item.last, "status result not clean")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "output dropped")
endmodule
